@@ rtl/c2p_pkg.sv @@
// shared types, constants and the arctangent table for the cartesian to polar converter
`default_nettype none

package c2p_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;

    // datapath: magnitudes shifted up by the guard bits, plus room for cordic growth and sign
    localparam int GUARD_BITS = 60 - COORD_WIDTH;
    localparam int DP_W       = COORD_WIDTH + GUARD_BITS + 2;
    localparam int Z_W        = 28;
    localparam int ANG_Q_FRAC = 20;
    localparam int ANG_Q_W    = 29;
    localparam int STAGE_W    = 5;
    localparam int XR_W       = DP_W - 1 - (GUARD_BITS - 8);
    localparam int P_W        = XR_W + 17;
    localparam int ANGLE_W    = 9 + ANGLE_FRAC_BITS;
    localparam int DROP       = ANG_Q_FRAC - ANGLE_FRAC_BITS;

    localparam logic [ANG_Q_W-1:0] DEG90  = ANG_Q_W'(90 * (1 << ANG_Q_FRAC));
    localparam logic [ANG_Q_W-1:0] DEG180 = ANG_Q_W'(180 * (1 << ANG_Q_FRAC));
    localparam logic [ANG_Q_W-1:0] DEG270 = ANG_Q_W'(270 * (1 << ANG_Q_FRAC));
    localparam logic [ANG_Q_W-1:0] DEG360 = ANG_Q_W'(360 * (1 << ANG_Q_FRAC));
    localparam logic [ANGLE_W:0]   ANGLE_FULL = (ANGLE_W + 1)'(360) << ANGLE_FRAC_BITS;

    // 1/gain in q32, split into two 16-bit halves for the partial products
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam logic [15:0] INV_GAIN_HI  = INV_GAIN_Q32[31:16];
    localparam logic [15:0] INV_GAIN_LO  = INV_GAIN_Q32[15:0];

    typedef enum logic [2:0] {
        POS_ORIGIN = 3'd0,
        POS_Q1     = 3'd1,
        POS_Q2     = 3'd2,
        POS_Q3     = 3'd3,
        POS_Q4     = 3'd4,
        POS_YAXIS  = 3'd5,
        POS_XAXIS  = 3'd6
    } t_pos;

    typedef struct packed {
        t_pos                   pos;
        logic                   neg;
        logic [COORD_WIDTH-1:0] mag;
    } t_side;

    typedef struct packed {
        logic signed [DP_W-1:0] cx;
        logic signed [DP_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        t_side                  side;
    } t_cell;

    // atan(2^-i) in degrees, q20
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [STAGE_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 28'sd47185920;
            5'd1:    v = 28'sd27855475;
            5'd2:    v = 28'sd14718068;
            5'd3:    v = 28'sd7471121;
            5'd4:    v = 28'sd3750058;
            5'd5:    v = 28'sd1876857;
            5'd6:    v = 28'sd938658;
            5'd7:    v = 28'sd469357;
            5'd8:    v = 28'sd234682;
            5'd9:    v = 28'sd117342;
            5'd10:   v = 28'sd58671;
            5'd11:   v = 28'sd29335;
            5'd12:   v = 28'sd14668;
            5'd13:   v = 28'sd7334;
            5'd14:   v = 28'sd3667;
            5'd15:   v = 28'sd1833;
            5'd16:   v = 28'sd917;
            5'd17:   v = 28'sd458;
            5'd18:   v = 28'sd229;
            5'd19:   v = 28'sd115;
            5'd20:   v = 28'sd57;
            5'd21:   v = 28'sd29;
            5'd22:   v = 28'sd14;
            5'd23:   v = 28'sd7;
            5'd24:   v = 28'sd4;
            5'd25:   v = 28'sd2;
            5'd26:   v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cartesian_to_polar.sv @@
// cartesian to polar converter: input folding, cordic cell chain and output stage
`default_nettype none

// channel   direction  handshake            fields
// input     in         i_valid / o_ready    i_x_coord, i_y_coord
// output    out        o_valid / i_ready    o_radius, o_angle_deg, o_position
//
// one point per cycle sustained while the output is not stalled; the path runs through 16 cells, then
// one product stage and the output register
// every cell holds one beat and has its own ready, so bubbles close up under a stall
// and new beats are taken while a result waits at the output
// synchronous active-low reset clears only the valid bits

module cartesian_to_polar (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [c2p_pkg::COORD_WIDTH-1:0] i_y_coord,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [c2p_pkg::COORD_WIDTH-1:0]         o_radius,
    output logic [c2p_pkg::ANGLE_W-1:0]             o_angle_deg,
    output logic [2:0]                              o_position
);

    logic                           chain_valid [0:c2p_pkg::CORDIC_STAGES];
    logic                           chain_ready [0:c2p_pkg::CORDIC_STAGES];
    c2p_pkg::t_cell                 chain_data  [0:c2p_pkg::CORDIC_STAGES];

    logic [c2p_pkg::COORD_WIDTH-1:0] ax;
    logic [c2p_pkg::COORD_WIDTH-1:0] ay;
    logic                            x_zero;
    logic                            y_zero;
    logic                            x_neg;
    logic                            y_neg;
    c2p_pkg::t_side                  side;

    assign x_neg  = i_x_coord[c2p_pkg::COORD_WIDTH-1];
    assign y_neg  = i_y_coord[c2p_pkg::COORD_WIDTH-1];
    assign x_zero = (i_x_coord == '0);
    assign y_zero = (i_y_coord == '0);
    assign ax     = x_neg ? (~i_x_coord + 1'b1) : i_x_coord;
    assign ay     = y_neg ? (~i_y_coord + 1'b1) : i_y_coord;

    // classify the point; axis points carry their exact radius alongside the chain
    always_comb begin
        side.neg = 1'b0;
        side.mag = '0;
        if (x_zero && y_zero) begin
            side.pos = c2p_pkg::POS_ORIGIN;
        end else if (x_zero) begin
            side.pos = c2p_pkg::POS_YAXIS;
            side.neg = y_neg;
            side.mag = ay;
        end else if (y_zero) begin
            side.pos = c2p_pkg::POS_XAXIS;
            side.neg = x_neg;
            side.mag = ax;
        end else if (!x_neg && !y_neg) begin
            side.pos = c2p_pkg::POS_Q1;
        end else if (x_neg && !y_neg) begin
            side.pos = c2p_pkg::POS_Q2;
        end else if (x_neg) begin
            side.pos = c2p_pkg::POS_Q3;
        end else begin
            side.pos = c2p_pkg::POS_Q4;
        end
    end

    // fold into the first quadrant and scale up by the guard bits
    assign chain_data[0].cx   = signed'({2'b00, ax, {c2p_pkg::GUARD_BITS{1'b0}}});
    assign chain_data[0].cy   = signed'({2'b00, ay, {c2p_pkg::GUARD_BITS{1'b0}}});
    assign chain_data[0].z    = '0;
    assign chain_data[0].side = side;
    assign chain_valid[0]     = i_valid;
    assign o_ready            = chain_ready[0];

    for (genvar k = 0; k < c2p_pkg::CORDIC_STAGES; k++) begin : g_cell
        c2p_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (c2p_pkg::STAGE_W'(k)),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    c2p_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chain_valid[c2p_pkg::CORDIC_STAGES]),
        .o_ready     (chain_ready[c2p_pkg::CORDIC_STAGES]),
        .i_data      (chain_data[c2p_pkg::CORDIC_STAGES]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_radius    (o_radius),
        .o_angle_deg (o_angle_deg),
        .o_position  (o_position)
    );

endmodule

`default_nettype wire

@@ rtl/c2p_cell.sv @@
// one cordic vectoring iteration with its own pipeline register and ready chain
`default_nettype none

module c2p_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [c2p_pkg::STAGE_W-1:0]   i_stage,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire c2p_pkg::t_cell                i_data,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output c2p_pkg::t_cell                     o_data
);

    logic                          r_valid;
    c2p_pkg::t_cell                r_data;
    c2p_pkg::t_cell                n_data;
    logic signed [c2p_pkg::DP_W-1:0] dx;
    logic signed [c2p_pkg::DP_W-1:0] dy;
    logic signed [c2p_pkg::Z_W-1:0]  atan_v;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign dx     = i_data.cy >>> i_stage;
    assign dy     = i_data.cx >>> i_stage;
    assign atan_v = c2p_pkg::atan_q20(i_stage);

    // rotate toward the x axis by the sign of y
    always_comb begin
        n_data = i_data;
        if (!i_data.cy[c2p_pkg::DP_W-1]) begin
            n_data.cx = i_data.cx + dx;
            n_data.cy = i_data.cy - dy;
            n_data.z  = i_data.z + atan_v;
        end else begin
            n_data.cx = i_data.cx - dx;
            n_data.cy = i_data.cy + dy;
            n_data.z  = i_data.z - atan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/c2p_post.sv @@
// gain compensation, quadrant mapping, rounding and the output register
`default_nettype none

module c2p_post (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire c2p_pkg::t_cell                    i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [c2p_pkg::COORD_WIDTH-1:0]        o_radius,
    output logic [c2p_pkg::ANGLE_W-1:0]            o_angle_deg,
    output logic [2:0]                             o_position
);

    // first stage: partial products and the q20 angle
    logic                                  r_s1_valid;
    logic [c2p_pkg::XR_W+15:0]             r_p_hi;
    logic [c2p_pkg::XR_W-1:0]              r_p_lo;
    logic [c2p_pkg::ANG_Q_W-1:0]           r_angq;
    c2p_pkg::t_side                        r_side;

    logic                                  r_o_valid;
    logic [c2p_pkg::COORD_WIDTH-1:0]       r_radius;
    logic [c2p_pkg::ANGLE_W-1:0]           r_angle;
    logic [2:0]                            r_pos;

    logic                                  s1_ready;
    logic                                  s2_ready;
    logic [c2p_pkg::Z_W-2:0]               zu;
    logic [c2p_pkg::ANG_Q_W-1:0]           zc;
    logic [c2p_pkg::XR_W-1:0]              xr;
    logic [c2p_pkg::XR_W+15:0]             n_p_hi;
    logic [c2p_pkg::XR_W+15:0]             lo_full;
    logic [c2p_pkg::ANG_Q_W-1:0]           n_angq;

    logic [c2p_pkg::P_W-1:0]               p_sum;
    logic [c2p_pkg::P_W-1:0]               p_rnd;
    logic [c2p_pkg::ANG_Q_W:0]             ang_rnd;
    logic [c2p_pkg::ANGLE_W:0]             ang_a;
    logic [c2p_pkg::ANGLE_W:0]             ang_w;
    logic [c2p_pkg::COORD_WIDTH-1:0]       n_radius;

    assign s2_ready = !r_o_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    // clamp the accumulated angle to the first quadrant
    assign zu = i_data.z[c2p_pkg::Z_W-2:0];
    always_comb begin
        if (i_data.z[c2p_pkg::Z_W-1]) begin
            zc = '0;
        end else if (c2p_pkg::ANG_Q_W'(zu) > c2p_pkg::DEG90) begin
            zc = c2p_pkg::DEG90;
        end else begin
            zc = c2p_pkg::ANG_Q_W'(zu);
        end
    end

    // negative x clamps to zero, then keep 8 guard bits
    assign xr = i_data.cx[c2p_pkg::DP_W-1] ? '0
              : i_data.cx[c2p_pkg::DP_W-2:c2p_pkg::GUARD_BITS-8];
    assign n_p_hi  = xr * c2p_pkg::INV_GAIN_HI;
    assign lo_full = xr * c2p_pkg::INV_GAIN_LO;

    always_comb begin
        case (i_data.side.pos)
            c2p_pkg::POS_Q1:    n_angq = zc;
            c2p_pkg::POS_Q2:    n_angq = c2p_pkg::DEG180 - zc;
            c2p_pkg::POS_Q3:    n_angq = c2p_pkg::DEG180 + zc;
            c2p_pkg::POS_Q4:    n_angq = c2p_pkg::DEG360 - zc;
            c2p_pkg::POS_YAXIS: n_angq = i_data.side.neg ? c2p_pkg::DEG270 : c2p_pkg::DEG90;
            c2p_pkg::POS_XAXIS: n_angq = i_data.side.neg ? c2p_pkg::DEG180 : '0;
            default:            n_angq = '0;
        endcase
    end

    // radius rounding half up from 24 fraction bits
    assign p_sum = c2p_pkg::P_W'(r_p_hi) + c2p_pkg::P_W'(r_p_lo);
    assign p_rnd = p_sum + (c2p_pkg::P_W'(1) << 23);

    always_comb begin
        case (r_side.pos)
            c2p_pkg::POS_Q1,
            c2p_pkg::POS_Q2,
            c2p_pkg::POS_Q3,
            c2p_pkg::POS_Q4: n_radius = p_rnd[c2p_pkg::COORD_WIDTH+23:24];
            default:         n_radius = r_side.mag;
        endcase
    end

    // angle rounding half up, a full turn wraps to zero
    assign ang_rnd = {1'b0, r_angq} + ((c2p_pkg::ANG_Q_W + 1)'(1) << (c2p_pkg::DROP - 1));
    assign ang_a   = ang_rnd[c2p_pkg::ANG_Q_W:c2p_pkg::DROP];
    assign ang_w   = (ang_a >= c2p_pkg::ANGLE_FULL) ? ang_a - c2p_pkg::ANGLE_FULL : ang_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
        if (i_valid && s1_ready) begin
            r_p_hi <= n_p_hi;
            r_p_lo <= lo_full[c2p_pkg::XR_W+15:16];
            r_angq <= n_angq;
            r_side <= i_data.side;
        end
        if (r_s1_valid && s2_ready) begin
            r_radius <= n_radius;
            r_angle  <= ang_w[c2p_pkg::ANGLE_W-1:0];
            r_pos    <= r_side.pos;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_radius    = r_radius;
    assign o_angle_deg = r_angle;
    assign o_position  = r_pos;

endmodule

`default_nettype wire

@@ tb/cartesian_to_polar_tb.sv @@
// self-checking testbench for the cartesian to polar converter with random handshake pressure
module cartesian_to_polar_tb;

    localparam int CW         = c2p_pkg::COORD_WIDTH;
    localparam int AW         = c2p_pkg::ANGLE_W;
    localparam int GUARD      = 60 - CW;
    localparam int Q_FRAC     = 20;
    localparam int ROUND_DROP = Q_FRAC - c2p_pkg::ANGLE_FRAC_BITS;
    localparam longint DEG_ONE = 64'sd1 <<< Q_FRAC;
    localparam longint unsigned TURN_CODE = 64'd360 << c2p_pkg::ANGLE_FRAC_BITS;
    localparam longint unsigned INV_GAIN  = 64'd2608131496;
    localparam int HOLD_CYCLES = 300;
    localparam int DIR_N = 22;

    // atan(2^-i) in degrees, q20
    localparam longint ATAN_DEG_Q20 [0:31] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0, 0, 0, 0, 0
    };

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [CW-1:0] radius;
        logic [AW-1:0] angle;
        c2p_pkg::t_pos pos;
    } t_polar;

    class polar_scoreboard;
        t_polar      pending_q[$];
        int unsigned failures;

        static function t_polar polar_of(t_coord x, t_coord y);
            longint sx, sy, ax, ay, cx, cy, dx, dy, z, ang;
            longint unsigned xr, p, a;
            t_polar r;
            sx = x;
            sy = y;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            if (sx == 0 && sy == 0) begin
                r.radius = '0;
                r.pos    = c2p_pkg::POS_ORIGIN;
                ang      = 0;
            end else if (sx == 0) begin
                r.radius = CW'(ay);
                r.pos    = c2p_pkg::POS_YAXIS;
                ang      = (sy > 0 ? 90 : 270) * DEG_ONE;
            end else if (sy == 0) begin
                r.radius = CW'(ax);
                r.pos    = c2p_pkg::POS_XAXIS;
                ang      = (sx > 0 ? 0 : 180) * DEG_ONE;
            end else begin
                cx = ax <<< GUARD;
                cy = ay <<< GUARD;
                z  = 0;
                for (int i = 0; i < c2p_pkg::CORDIC_STAGES && i < 32; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0) begin
                        cx += dx;
                        cy -= dy;
                        z  += ATAN_DEG_Q20[i];
                    end else begin
                        cx -= dx;
                        cy += dy;
                        z  -= ATAN_DEG_Q20[i];
                    end
                end
                if (z < 0) z = 0;
                if (z > 90 * DEG_ONE) z = 90 * DEG_ONE;
                if (cx < 0) cx = 0;
                // keep 8 guard bits, then multiply by 1/gain as two 16-bit partial products
                xr = longint'(cx) >> (GUARD - 8);
                p  = xr * (INV_GAIN >> 16) + ((xr * (INV_GAIN & 64'hFFFF)) >> 16);
                r.radius = CW'((p + (64'd1 << 23)) >> 24);
                if (sx > 0 && sy > 0) begin
                    r.pos = c2p_pkg::POS_Q1;
                    ang   = z;
                end else if (sx < 0 && sy > 0) begin
                    r.pos = c2p_pkg::POS_Q2;
                    ang   = 180 * DEG_ONE - z;
                end else if (sx < 0) begin
                    r.pos = c2p_pkg::POS_Q3;
                    ang   = 180 * DEG_ONE + z;
                end else begin
                    r.pos = c2p_pkg::POS_Q4;
                    ang   = 360 * DEG_ONE - z;
                end
            end
            a = (longint'(ang) + (64'd1 << (ROUND_DROP - 1))) >> ROUND_DROP;
            // a full turn after rounding wraps to zero
            if (a >= TURN_CODE) a -= TURN_CODE;
            r.angle = AW'(a);
            return r;
        endfunction

        function void note_point(t_coord x, t_coord y);
            pending_q.push_back(polar_of(x, y));
        endfunction

        function void check_result(logic [CW-1:0] radius, logic [AW-1:0] angle,
                                   logic [2:0] position);
            t_polar want;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing pending: radius %0d angle %0d position %0d",
                       radius, angle, position);
                failures++;
                return;
            end
            want = pending_q.pop_front();
            if (want.radius !== radius) begin
                $error("radius mismatch: expected %0d, actual %0d", want.radius, radius);
                failures++;
            end
            if (want.angle !== angle) begin
                $error("angle_deg mismatch: expected %0d, actual %0d", want.angle, angle);
                failures++;
            end
            if (3'(want.pos) !== position) begin
                $error("position mismatch: expected %0d, actual %0d", 3'(want.pos), position);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_coord               i_x_coord;
    t_coord               i_y_coord;
    logic                 o_valid;
    logic                 i_ready;
    logic [CW-1:0]        o_radius;
    logic [AW-1:0]        o_angle_deg;
    logic [2:0]           o_position;

    polar_scoreboard board = new;
    int  sender_idle_pct   = 0;
    int  receiver_idle_pct = 0;
    bit  long_stall_req    = 1'b0;

    int dir_x [DIR_N] = '{0, 32767, -32768, 0, 0, 1, 0, 1, -1, -1, 1,
                          32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768,
                          1, -1, 3};
    int dir_y [DIR_N] = '{0, 0, 0, 32767, -32768, 0, -1, 1, 1, -1, -1,
                          32767, 32767, -32768, -32768, -1, 1, 1, -1,
                          32767, -32768, 4};

    cartesian_to_polar dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_x_coord  (i_x_coord),
        .i_y_coord  (i_y_coord),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_radius   (o_radius),
        .o_angle_deg(o_angle_deg),
        .o_position (o_position)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_point(input t_coord x, input t_coord y);
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_point(x, y);
    endtask

    // each cycle the sender idles with the current percentage
    task automatic sender_gap();
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // mix of full range, values near zero (axes and origin) and extremes
    function automatic t_coord random_coord();
        int unsigned kind;
        t_coord v;
        kind = $urandom_range(99);
        if (kind < 60) begin
            v = t_coord'($urandom);
        end else if (kind < 80) begin
            v = t_coord'($urandom_range(16));
            v = v - 8;
        end else if (kind < 90) begin
            v = '0;
        end else begin
            case ($urandom_range(3))
                0:       v = 16'sh8000;
                1:       v = 16'sh7FFF;
                2:       v = -16'sd1;
                default: v = 16'sd1;
            endcase
        end
        return v;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_point(random_coord(), random_coord());
            sender_gap();
        end
    endtask

    // receiver: check every accepted beat, stall at random, one long hold on request
    initial begin
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                board.check_result(o_radius, o_angle_deg, o_position);
            if (long_stall_req) begin
                long_stall_req <= 1'b0;
                i_ready        <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_x_coord <= '0;
        i_y_coord <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 22;
        receiver_idle_pct = 59;
        for (int k = 0; k < DIR_N; k++) begin
            send_point(t_coord'(dir_x[k]), t_coord'(dir_y[k]));
            sender_gap();
        end
        send_random(620);

        sender_idle_pct   = 59;
        receiver_idle_pct = 22;
        send_random(310);
        wait_drained();
        send_random(310);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random(100);
        // receiver holds off while points keep coming, so the pipe fills and backs up
        long_stall_req <= 1'b1;
        send_random(540);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
